@@ sv/http_request_line_checker_top_macros.svh @@
// assertion macros for the http request line checker
`ifndef HTTP_REQUEST_LINE_CHECKER_TOP_MACROS_SVH
`define HTTP_REQUEST_LINE_CHECKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// check a property at each clock edge outside of reset
`define HRLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("hrlc assertion failed");

// check a property at each clock edge, reset included
`define HRLC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hrlc assertion failed");

`else

`define HRLC_ASSERT(lbl, clk, rst_n, prop)
`define HRLC_ASSERT_NR(lbl, clk, prop)

`endif

`endif

@@ sv/hrlc_pkg.sv @@
// types, codes and character tables for the http request line checker
`default_nettype none

package hrlc_pkg;

    // byte roles
    localparam logic [2:0] ROLE_METHOD  = 3'd0;
    localparam logic [2:0] ROLE_TARGET  = 3'd1;
    localparam logic [2:0] ROLE_VERSION = 3'd2;
    localparam logic [2:0] ROLE_TERM    = 3'd3;
    localparam logic [2:0] ROLE_AFTER   = 3'd4;

    // status codes
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_OK          = 3'd1;
    localparam logic [2:0] ST_MALFORMED   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_BAD_METHOD  = 3'd4;
    localparam logic [2:0] ST_DONE        = 3'd5;

    // method codes
    localparam logic [1:0] METH_NONE   = 2'd0;
    localparam logic [1:0] METH_GET    = 2'd1;
    localparam logic [1:0] METH_POST   = 2'd2;
    localparam logic [1:0] METH_DELETE = 2'd3;

    // method table indexes
    localparam logic [1:0] MIDX_GET    = 2'd0;
    localparam logic [1:0] MIDX_POST   = 2'd1;
    localparam logic [1:0] MIDX_DELETE = 2'd2;

    // special characters
    localparam logic [7:0] CHR_SP = 8'h20;
    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;

    // version text length and saturation points
    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] VPOS_MAX    = 4'd15;
    localparam logic [2:0] MPOS_MAX    = 3'd7;

    // request line phase
    typedef enum logic [1:0] {
        PH_LINE  = 2'd0,
        PH_DONE  = 2'd1,
        PH_ERROR = 2'd2
    } t_phase;

    // length of each method name
    function automatic logic [2:0] method_len(input logic [1:0] idx);
        logic [2:0] len;
        unique case (idx)
            MIDX_GET:    len = 3'd3;
            MIDX_POST:   len = 3'd4;
            MIDX_DELETE: len = 3'd6;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    // character of a method name at a position
    function automatic logic [7:0] method_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            MIDX_GET: begin
                unique case (pos)
                    3'd0:    c = "G";
                    3'd1:    c = "E";
                    3'd2:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            MIDX_POST: begin
                unique case (pos)
                    3'd0:    c = "P";
                    3'd1:    c = "O";
                    3'd2:    c = "S";
                    3'd3:    c = "T";
                    default: c = 8'h00;
                endcase
            end
            MIDX_DELETE: begin
                unique case (pos)
                    3'd0:    c = "D";
                    3'd1:    c = "E";
                    3'd2:    c = "L";
                    3'd3:    c = "E";
                    3'd4:    c = "T";
                    3'd5:    c = "E";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // character of the version text at a position
    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            3'd5:    c = "1";
            3'd6:    c = ".";
            3'd7:    c = "1";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // method code for the candidates left when the method ends
    function automatic logic [1:0] resolve_method(input logic [2:0] cand, input logic [2:0] pos);
        logic [1:0] code;
        if (cand[MIDX_GET] && pos == method_len(MIDX_GET)) begin
            code = METH_GET;
        end else if (cand[MIDX_POST] && pos == method_len(MIDX_POST)) begin
            code = METH_POST;
        end else if (cand[MIDX_DELETE] && pos == method_len(MIDX_DELETE)) begin
            code = METH_DELETE;
        end else begin
            code = METH_NONE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

@@ sv/http_request_line_checker_top.sv @@
// Request line checker: input register, combinational parse logic, result register.
// Each byte is taken into the input register, and its result into the result register behind it.
// Throughput: one byte per cycle unless results stall, with combinational parse logic.
// The input stage takes a beat whenever it is empty or moves on, also while a result waits.
// Reset (synchronous, active low) empties both stages and returns the parser to line start.
`default_nettype none
`include "http_request_line_checker_top_macros.svh"

module http_request_line_checker_top
    import hrlc_pkg::*;
#(
    parameter int TARGET_COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_new_request,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_byte_out,
    output logic [2:0]       o_role,
    output logic [2:0]       o_status,
    output logic [1:0]       o_method_code,
    output logic [15:0]      o_target_length
);

    localparam int TL_W = 16;

    // parser state of the request line
    typedef struct packed {
        logic [1:0]                   spaces;
        logic [2:0]                   mpos;
        logic [2:0]                   mcand;
        logic [3:0]                   vpos;
        logic                         vmatch;
        logic [2:0]                   herr;
        logic [1:0]                   mmeth;
        logic [TARGET_COUNT_BITS-1:0] tcnt;
    } t_line;

    // one line byte step: new state and role of the byte
    typedef struct packed {
        t_line      s;
        logic [2:0] role;
    } t_step;

    localparam t_line LINE_RESET = '{
        spaces: 2'd0,
        mpos:   3'd0,
        mcand:  3'b111,
        vpos:   4'd0,
        vmatch: 1'b1,
        herr:   ST_NONE,
        mmeth:  METH_NONE,
        tcnt:   '0
    };

    // ordinary byte of the request line
    function automatic t_step line_byte(input t_line s, input logic [7:0] b);
        t_step r;
        r.s = s;
        r.role = ROLE_METHOD;
        if (b == CHR_SP) begin
            case (s.spaces)
                2'd0: begin
                    if (s.mpos == 3'd0) begin
                        r.s.herr = ST_MALFORMED;
                    end
                    r.s.mmeth = resolve_method(s.mcand, s.mpos);
                    r.s.spaces = 2'd1;
                    r.role = ROLE_TARGET;
                end
                2'd1: begin
                    if (s.tcnt == '0) begin
                        r.s.herr = ST_MALFORMED;
                    end
                    r.s.spaces = 2'd2;
                    r.role = ROLE_VERSION;
                end
                default: begin
                    r.s.herr = ST_MALFORMED;
                    r.s.spaces = 2'd3;
                    r.role = ROLE_VERSION;
                end
            endcase
        end else begin
            case (s.spaces)
                2'd0: begin
                    for (int i = 0; i < 3; i++) begin
                        if (s.mpos >= method_len(2'(i)) || method_char(2'(i), s.mpos) != b) begin
                            r.s.mcand[i] = 1'b0;
                        end
                    end
                    if (s.mpos != MPOS_MAX) begin
                        r.s.mpos = s.mpos + 3'd1;
                    end
                    r.role = ROLE_METHOD;
                end
                2'd1: begin
                    if (s.tcnt != '1) begin
                        r.s.tcnt = s.tcnt + 1'b1;
                    end
                    r.role = ROLE_TARGET;
                end
                default: begin
                    if (s.spaces == 2'd3 || s.vpos >= VERSION_LEN
                        || version_char(s.vpos[2:0]) != b) begin
                        r.s.vmatch = 1'b0;
                    end
                    if (s.vpos != VPOS_MAX) begin
                        r.s.vpos = s.vpos + 4'd1;
                    end
                    r.role = ROLE_VERSION;
                end
            endcase
        end
        return r;
    endfunction

    // verdict on the line at its terminating lf
    function automatic logic [2:0] verdict(input t_line s);
        logic [2:0] v;
        if (s.herr == ST_MALFORMED || s.spaces != 2'd2 || s.vpos == 4'd0) begin
            v = ST_MALFORMED;
        end else if (!s.vmatch || s.vpos != VERSION_LEN) begin
            v = ST_BAD_VERSION;
        end else if (s.mmeth == METH_NONE) begin
            v = ST_BAD_METHOD;
        end else begin
            v = ST_OK;
        end
        return v;
    endfunction

    // pipeline control
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_new;
    logic        s2_ready;
    logic        s2_fire;

    // parser state
    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_cr;
    logic        n_cr;
    t_line       r_line;
    t_line       n_line;

    // shared parse signals
    t_phase      base_phase;
    logic        base_cr;
    t_line       base_line;
    t_step       step_cr;
    t_step       step_b;
    t_line       line_in;
    logic        is_term;
    logic [2:0]  vd;
    logic [2:0]  n_role;
    logic [2:0]  n_status;
    logic [TL_W-1:0] n_tlen;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_byte_out;
    logic [2:0]  r_role;
    logic [2:0]  r_status;
    logic [1:0]  r_method;
    logic [TL_W-1:0] r_tlen;

    // handshake
    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s2_fire    = r_in_valid && s2_ready;
    assign o_in_ready = !r_in_valid || s2_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
            r_in_new  <= i_new_request;
        end
    end

    // state seen by this byte, after a new request clear
    assign base_phase = r_in_new ? PH_LINE : r_phase;
    assign base_cr    = r_in_new ? 1'b0 : r_cr;
    assign base_line  = r_in_new ? LINE_RESET : r_line;

    // pending cr taken as a line byte, then the byte itself
    assign step_cr = line_byte(base_line, CHR_CR);
    assign line_in = base_cr ? step_cr.s : base_line;
    assign step_b  = line_byte(line_in, r_in_byte);
    assign is_term = base_cr && r_in_byte == CHR_LF;
    assign vd      = verdict(base_line);

    // next parser state
    always_comb begin
        n_phase = base_phase;
        n_cr    = base_cr;
        n_line  = base_line;
        if (base_phase == PH_LINE) begin
            if (is_term) begin
                n_cr = 1'b0;
                if (vd == ST_OK) begin
                    n_phase     = PH_DONE;
                    n_line.herr = ST_NONE;
                end else begin
                    n_phase     = PH_ERROR;
                    n_line.herr = vd;
                end
            end else if (r_in_byte == CHR_CR) begin
                n_cr   = 1'b1;
                n_line = line_in;
            end else begin
                n_cr   = 1'b0;
                n_line = step_b.s;
            end
        end
    end

    // result fields
    always_comb begin
        if (base_phase == PH_DONE) begin
            n_role   = ROLE_AFTER;
            n_status = ST_DONE;
        end else if (base_phase != PH_LINE) begin
            n_role   = ROLE_AFTER;
            n_status = base_line.herr;
        end else if (is_term) begin
            n_role   = ROLE_TERM;
            n_status = vd;
        end else if (r_in_byte == CHR_CR) begin
            n_role   = ROLE_TERM;
            n_status = ST_NONE;
        end else begin
            n_role   = step_b.role;
            n_status = ST_NONE;
        end
    end

    // target length shown saturated at the port width
    generate
        if (TARGET_COUNT_BITS > TL_W) begin : g_tlen_sat
            assign n_tlen = (|n_line.tcnt[TARGET_COUNT_BITS-1:TL_W])
                          ? {TL_W{1'b1}} : n_line.tcnt[TL_W-1:0];
        end else begin : g_tlen_ext
            assign n_tlen = TL_W'(n_line.tcnt);
        end
    endgenerate

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_cr    <= 1'b0;
            r_line  <= LINE_RESET;
        end else if (s2_fire) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_line  <= n_line;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_in_valid;
        end
        if (s2_fire) begin
            r_byte_out <= r_in_byte;
            r_role     <= n_role;
            r_status   <= n_status;
            r_method   <= n_line.mmeth;
            r_tlen     <= n_tlen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_byte_out;
    assign o_role          = r_role;
    assign o_status        = r_status;
    assign o_method_code   = r_method;
    assign o_target_length = r_tlen;

    // checks
    `HRLC_ASSERT(a_done_after_line, i_clk, i_rst_n, (o_out_valid && o_status == ST_DONE) |-> (o_role == ROLE_AFTER))
    `HRLC_ASSERT(a_after_has_verdict, i_clk, i_rst_n, (o_out_valid && o_role == ROLE_AFTER) |-> (o_status != ST_NONE && o_status != ST_OK))
    `HRLC_ASSERT(a_ok_on_term, i_clk, i_rst_n, (o_out_valid && o_status == ST_OK) |-> (o_role == ROLE_TERM && o_method_code != METH_NONE))
    `HRLC_ASSERT(a_done_no_error, i_clk, i_rst_n, (r_phase == PH_DONE) |-> (r_line.herr == ST_NONE))
    `HRLC_ASSERT_NR(a_reset_empties, i_clk, (!i_rst_n) |=> (!o_out_valid && !r_in_valid))

endmodule

`default_nettype wire

@@ tb/http_request_line_checker_top_tb.sv @@
// testbench for the http request line checker: directed rows, random requests, scoreboard
`timescale 1ns / 1ps

module http_request_line_checker_top_tb;
    import hrlc_pkg::*;

    localparam int TCB             = 16;
    localparam int RANDOM_BEATS    = 625;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DIR_ROWS        = 25;

    // method names right-aligned in 48 bits, with their lengths and codes
    localparam logic [47:0] METHOD_TEXT [3] = '{"GET", "POST", "DELETE"};
    localparam logic [2:0]  METHOD_LEN  [3] = '{3'd3, 3'd4, 3'd6};
    localparam logic [1:0]  METHOD_CODE [3] = '{METH_GET, METH_POST, METH_DELETE};
    localparam logic [63:0] VERSION_TEXT    = "HTTP/1.1";

    // one result beat
    typedef struct packed {
        logic [7:0]  echo;
        logic [2:0]  role;
        logic [2:0]  status;
        logic [1:0]  method;
        logic [15:0] tlen;
    } t_line_result;

    // one directed row; typed rows carry their own expected result
    typedef struct packed {
        logic [7:0]   data;
        logic         fresh;
        logic         typed;
        t_line_result want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  in_byte       = 8'h00;
    logic        in_fresh      = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_byte_out;
    logic [2:0]  o_role;
    logic [2:0]  o_status;
    logic [1:0]  o_method_code;
    logic [15:0] o_target_length;

    bit           idle_on = 1'b1;
    int           fails   = 0;
    int           beats_sent = 0;
    t_line_result line_results [$];
    logic [7:0]   line_bytes [$];

    // parser state mirror
    t_phase         ph;
    logic [1:0]     spaces;
    logic [2:0]     mpos;
    logic [2:0]     mcand;
    logic [3:0]     vpos;
    logic           vmatch;
    logic           cr_pending;
    logic [TCB-1:0] tcount;
    logic [2:0]     held_err;
    logic [1:0]     meth;

    http_request_line_checker_top #(
        .TARGET_COUNT_BITS(TCB)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_byte_in       (in_byte),
        .i_new_request   (in_fresh),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_out      (o_byte_out),
        .o_role          (o_role),
        .o_status        (o_status),
        .o_method_code   (o_method_code),
        .o_target_length (o_target_length)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // back to line start
    function automatic void clear_parser();
        ph         = PH_LINE;
        spaces     = 2'd0;
        mpos       = 3'd0;
        mcand      = 3'b111;
        vpos       = 4'd0;
        vmatch     = 1'b1;
        cr_pending = 1'b0;
        tcount     = '0;
        held_err   = ST_NONE;
        meth       = METH_NONE;
    endfunction

    // one ordinary request line byte; returns its role
    function automatic logic [2:0] line_char_role(input logic [7:0] c);
        logic [2:0] role;
        if (c == CHR_SP) begin
            if (spaces == 2'd0) begin
                if (mpos == 3'd0) held_err = ST_MALFORMED;
                meth = METH_NONE;
                for (int i = 2; i >= 0; i--) begin
                    if (mcand[i] && mpos == METHOD_LEN[i]) meth = METHOD_CODE[i];
                end
                spaces = 2'd1;
            end else if (spaces == 2'd1) begin
                if (tcount == 0) held_err = ST_MALFORMED;
                spaces = 2'd2;
            end else begin
                held_err = ST_MALFORMED;
                spaces   = 2'd3;
            end
            role = (spaces >= 2'd2) ? ROLE_VERSION : ROLE_TARGET;
        end else if (spaces == 2'd0) begin
            for (int i = 0; i < 3; i++) begin
                if (mpos >= METHOD_LEN[i]) begin
                    mcand[i] = 1'b0;
                end else if (METHOD_TEXT[i][(int'(METHOD_LEN[i]) - 1 - int'(mpos)) * 8 +: 8]
                             != c) begin
                    mcand[i] = 1'b0;
                end
            end
            if (mpos < MPOS_MAX) mpos = mpos + 3'd1;
            role = ROLE_METHOD;
        end else if (spaces == 2'd1) begin
            if (tcount != '1) tcount = tcount + 1'b1;
            role = ROLE_TARGET;
        end else begin
            if (spaces == 2'd3 || vpos >= VERSION_LEN) begin
                vmatch = 1'b0;
            end else if (VERSION_TEXT[(7 - int'(vpos)) * 8 +: 8] != c) begin
                vmatch = 1'b0;
            end
            if (vpos < VPOS_MAX) vpos = vpos + 4'd1;
            role = ROLE_VERSION;
        end
        return role;
    endfunction

    // status given on the closing lf
    function automatic logic [2:0] line_verdict();
        logic [2:0] st;
        if (held_err == ST_MALFORMED || spaces != 2'd2 || vpos == 4'd0) begin
            st = ST_MALFORMED;
        end else if (!vmatch || vpos != VERSION_LEN) begin
            st = ST_BAD_VERSION;
        end else if (meth == METH_NONE) begin
            st = ST_BAD_METHOD;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    // expected result of one input beat, advancing the parser mirror
    function automatic t_line_result parse_beat(input logic [7:0] c, input logic fresh);
        t_line_result res;
        logic         done;
        if (fresh) clear_parser();
        res.role   = ROLE_METHOD;
        res.status = ST_NONE;
        if (ph == PH_DONE) begin
            res.role   = ROLE_AFTER;
            res.status = ST_DONE;
        end else if (ph != PH_LINE) begin
            res.role   = ROLE_AFTER;
            res.status = held_err;
        end else begin
            done = 1'b0;
            if (cr_pending) begin
                cr_pending = 1'b0;
                if (c == CHR_LF) begin
                    res.status = line_verdict();
                    res.role   = ROLE_TERM;
                    if (res.status == ST_OK) begin
                        ph       = PH_DONE;
                        held_err = ST_NONE;
                    end else begin
                        ph       = PH_ERROR;
                        held_err = res.status;
                    end
                    done = 1'b1;
                end else begin
                    // the held cr turns out to be a plain line byte
                    void'(line_char_role(CHR_CR));
                end
            end
            if (!done) begin
                if (c == CHR_CR) begin
                    cr_pending = 1'b1;
                    res.role   = ROLE_TERM;
                end else begin
                    res.role = line_char_role(c);
                end
            end
        end
        res.echo   = c;
        res.method = meth;
        res.tlen   = (tcount > 65535) ? 16'hFFFF : 16'(tcount);
        return res;
    endfunction

    // drive one input beat, wait for its acceptance and log what must come back
    task automatic send_beat(input logic [7:0] c, input logic fresh, input logic typed,
                             input t_line_result want);
        t_line_result got;
        while (idle_on && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_fresh <= fresh;
        do @(posedge i_clk); while (!o_in_ready);
        got = parse_beat(c, fresh);
        line_results.push_back(typed ? want : got);
        beats_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    // usually one space, sometimes none or two
    task automatic push_spaces();
        int pick;
        pick = $urandom_range(19);
        if (pick != 0) line_bytes.push_back(CHR_SP);
        if (pick == 1) line_bytes.push_back(CHR_SP);
    endtask

    // mostly well-formed request line with random content and some damage
    task automatic build_request_line();
        string names [3];
        string s;
        int    mode;
        names = '{"GET", "POST", "DELETE"};
        line_bytes.delete();

        // method: exact, truncated, extended, one letter changed or random letters
        mode = $urandom_range(9);
        s = names[$urandom_range(2)];
        if (mode == 6) s = s.substr(0, s.len() - 2);
        if (mode == 7) s = {s, "S"};
        if (mode == 8) s.putc($urandom_range(s.len() - 1), 8'($urandom_range(90, 65)));
        if (mode == 9) s = "";
        push_text(s);
        if (mode == 9) begin
            repeat ($urandom_range(9)) line_bytes.push_back(8'($urandom_range(90, 65)));
        end
        push_spaces();

        // target, now and then empty or with raw bytes
        if ($urandom_range(11) != 0) begin
            repeat ($urandom_range(8, 1)) begin
                if ($urandom_range(9) == 0) line_bytes.push_back(8'($urandom));
                else line_bytes.push_back(8'($urandom_range(126, 33)));
            end
        end
        push_spaces();

        // version
        s = "HTTP/1.1";
        case ($urandom_range(9))
            5: s = "";
            6: s.putc($urandom_range(7), 8'($urandom_range(126, 33)));
            7: s = s.substr(0, $urandom_range(6));
            8: s = {s, "1"};
            9: s = "HTTP/1.1HTTP/1.1X";
            default: ;
        endcase
        push_text(s);

        // terminator, sometimes missing or after a lone cr or a bare lf
        case ($urandom_range(19))
            0: ;
            1: begin
                line_bytes.push_back(CHR_CR);
                line_bytes.push_back(8'($urandom_range(126, 33)));
                line_bytes.push_back(CHR_CR);
                line_bytes.push_back(CHR_LF);
            end
            2: begin
                line_bytes.push_back(CHR_LF);
                line_bytes.push_back(CHR_CR);
                line_bytes.push_back(CHR_LF);
            end
            default: begin
                line_bytes.push_back(CHR_CR);
                line_bytes.push_back(CHR_LF);
            end
        endcase

        // header bytes past the line
        repeat ($urandom_range(3)) line_bytes.push_back(8'($urandom));
    endtask

    // result checker and output stall
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_results.size() == 0) begin
                $error("result beat with no expected result, byte_out %h", o_byte_out);
                fails++;
            end else begin
                want = line_results.pop_front();
                if (o_byte_out !== want.echo) begin
                    $error("byte_out: expected %h, actual %h", want.echo, o_byte_out);
                    fails++;
                end
                if (o_role !== want.role) begin
                    $error("role: expected %0d, actual %0d", want.role, o_role);
                    fails++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fails++;
                end
                if (o_method_code !== want.method) begin
                    $error("method_code: expected %0d, actual %0d", want.method, o_method_code);
                    fails++;
                end
                if (o_target_length !== want.tlen) begin
                    $error("target_length: expected %0d, actual %0d", want.tlen,
                           o_target_length);
                    fails++;
                end
            end
        end
        i_out_ready <= !idle_on || ($urandom_range(99) >= 25);
    end

    // watchdog on cycles without any beat
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial begin
        t_dir_row directed_rows [DIR_ROWS];
        logic     fresh;

        directed_rows = '{
            // good GET line, then one byte past it
            '{"G",   1'b1, 1'b1, '{"G", ROLE_METHOD, ST_NONE, METH_NONE, 16'd0}},
            '{"E",   1'b0, 1'b0, '0},
            '{"T",   1'b0, 1'b0, '0},
            '{" ",   1'b0, 1'b0, '0},
            '{"/",   1'b0, 1'b0, '0},
            '{" ",   1'b0, 1'b0, '0},
            '{"H",   1'b0, 1'b0, '0},
            '{"T",   1'b0, 1'b0, '0},
            '{"T",   1'b0, 1'b0, '0},
            '{"P",   1'b0, 1'b0, '0},
            '{"/",   1'b0, 1'b0, '0},
            '{"1",   1'b0, 1'b0, '0},
            '{".",   1'b0, 1'b0, '0},
            '{"1",   1'b0, 1'b0, '0},
            '{CHR_CR, 1'b0, 1'b0, '0},
            '{CHR_LF, 1'b0, 1'b1, '{CHR_LF, ROLE_TERM, ST_OK, METH_GET, 16'd1}},
            '{"x",   1'b0, 1'b1, '{"x", ROLE_AFTER, ST_DONE, METH_GET, 16'd1}},
            // byte extremes and a bare lf inside the method, line without spaces
            '{8'h00, 1'b1, 1'b1, '{8'h00, ROLE_METHOD, ST_NONE, METH_NONE, 16'd0}},
            '{CHR_LF, 1'b0, 1'b0, '0},
            '{CHR_CR, 1'b0, 1'b1, '{CHR_CR, ROLE_TERM, ST_NONE, METH_NONE, 16'd0}},
            '{CHR_LF, 1'b0, 1'b1, '{CHR_LF, ROLE_TERM, ST_MALFORMED, METH_NONE, 16'd0}},
            '{8'hFF, 1'b0, 1'b1, '{8'hFF, ROLE_AFTER, ST_MALFORMED, METH_NONE, 16'd0}},
            // leading space, then a lone cr that becomes a target byte
            '{" ",   1'b1, 1'b0, '0},
            '{CHR_CR, 1'b0, 1'b0, '0},
            '{" ",   1'b0, 1'b0, '0}
        };

        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (directed_rows[r]) begin
            send_beat(directed_rows[r].data, directed_rows[r].fresh, directed_rows[r].typed,
                      directed_rows[r].want);
        end

        // random request lines and noise, with a stretch of no idling
        while (beats_sent < DIR_ROWS + RANDOM_BEATS) begin
            idle_on <= !(beats_sent >= 250 && beats_sent < 400);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(12, 1)) begin
                    send_beat(8'($urandom), $urandom_range(4) == 0, 1'b0, '0);
                end
            end else begin
                build_request_line();
                foreach (line_bytes[i]) begin
                    if (i == 0) fresh = ($urandom_range(9) != 0);
                    else fresh = ($urandom_range(99) == 0);
                    send_beat(line_bytes[i], fresh, 1'b0, '0);
                end
            end
        end

        // drain
        in_valid <= 1'b0;
        while (line_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
